### hdl/bssi_pkg.sv
package bssi_pkg;

  localparam logic [8:0] MAX_DIM = 9'd256;

  localparam logic [8:0] RST_COLUMNS = 9'd8;
  localparam logic [8:0] RST_ROWS = 9'd8;
  localparam logic [1:0] RST_REPEAT = 2'd1;
  localparam logic [1:0] REPEAT_MIRROR = 2'd2;

  typedef logic signed [9:0] crd_t;
  typedef logic signed [19:0] acc_t;

  typedef enum logic [2:0] {
    REG_COLUMNS    = 3'd0,
    REG_ROWS       = 3'd1,
    REG_HOR_REPEAT = 3'd2,
    REG_VER_REPEAT = 3'd3,
    REG_CLOCKWISE  = 3'd4,
    REG_REVERSE    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LEG_0 = 2'd0,
    LEG_1 = 2'd1,
    LEG_2 = 2'd2,
    LEG_3 = 2'd3
  } leg_t;

endpackage

### hdl/box_snake_spiral_index.sv
// Spiral scan order index.
// Input channel: in_valid / in_ready carry one beat of col_x and row_y, a grid
// cell coordinate. Output channel: out_valid / out_ready carry one beat of
// order_index, sequence_length and out_of_range for every input beat, in order.
// A cell outside the configured grid gives order_index 0 and out_of_range 1.
// Configuration: cfg_write, cfg_index and cfg_data write one register per
// cycle (0 columns, 1 rows, 2 horizontal repeat, 3 vertical repeat,
// 4 clockwise, 5 reverse order). Write only while no beat is in flight.
// An accepted beat passes the stage A, B and C registers and then the output
// register. One beat is accepted every cycle while the output is not stalled. The four
// register stages are the fold and grid product, the ring search, the ring offset
// multiply with leg selection, and the final leg sum that feeds the output register.
// When the receiver holds out_ready low with a beat waiting, the whole pipeline
// holds and in_ready drops in the same cycle; nothing is lost or repeated.
// The synchronous reset empties the pipeline and loads an 8 by 8 grid, no
// mirroring, clockwise walk, forward order. There is no clearing pass.
module box_snake_spiral_index (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  col_x,
  input  logic [7:0]  row_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] order_index,
  output logic [16:0] sequence_length,
  output logic        out_of_range
);

  logic [8:0] grid_columns;
  logic [8:0] grid_rows;
  logic [1:0] hor_repeat;
  logic [1:0] ver_repeat;
  logic       clockwise;
  logic       reverse_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns  <= bssi_pkg::RST_COLUMNS;
      grid_rows     <= bssi_pkg::RST_ROWS;
      hor_repeat    <= bssi_pkg::RST_REPEAT;
      ver_repeat    <= bssi_pkg::RST_REPEAT;
      clockwise     <= 1'b1;
      reverse_order <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        bssi_pkg::REG_COLUMNS:    grid_columns  <= cfg_data;
        bssi_pkg::REG_ROWS:       grid_rows     <= cfg_data;
        bssi_pkg::REG_HOR_REPEAT: hor_repeat    <= cfg_data[1:0];
        bssi_pkg::REG_VER_REPEAT: ver_repeat    <= cfg_data[1:0];
        bssi_pkg::REG_CLOCKWISE:  clockwise     <= cfg_data[0];
        bssi_pkg::REG_REVERSE:    reverse_order <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic       adv;
  logic       hr2;
  logic       vr2;
  logic [1:0] fl;

  assign adv = !out_valid || out_ready;
  assign in_ready = adv;
  assign hr2 = (hor_repeat == bssi_pkg::REPEAT_MIRROR);
  assign vr2 = (ver_repeat == bssi_pkg::REPEAT_MIRROR);

  always_comb begin
    fl = bssi_pkg::LEG_0;
    if (!vr2 && hr2) begin
      fl = clockwise ? bssi_pkg::LEG_3 : bssi_pkg::LEG_0;
    end else if (vr2 && !hr2) begin
      fl = clockwise ? bssi_pkg::LEG_0 : bssi_pkg::LEG_3;
    end
  end

  // Stage A: clamp, range check, fold into the top-left region, grid product.
  logic [8:0]     cols_c;
  logic [8:0]     rows_c;
  logic [17:0]    prod;
  logic [17:0]    seq;
  bssi_pkg::crd_t x_in;
  bssi_pkg::crd_t y_in;
  bssi_pkg::crd_t cols_s;
  bssi_pkg::crd_t rows_s;
  bssi_pkg::crd_t x_fold;
  bssi_pkg::crd_t y_fold;
  bssi_pkg::crd_t fc;
  bssi_pkg::crd_t fr;
  logic           oor;

  always_comb begin
    cols_c = (grid_columns > bssi_pkg::MAX_DIM) ? bssi_pkg::MAX_DIM : grid_columns;
    rows_c = (grid_rows > bssi_pkg::MAX_DIM) ? bssi_pkg::MAX_DIM : grid_rows;
    prod   = cols_c * rows_c;
    seq    = prod >> ({1'b0, hr2} + {1'b0, vr2});
    x_in   = bssi_pkg::crd_t'({2'b00, col_x});
    y_in   = bssi_pkg::crd_t'({2'b00, row_y});
    cols_s = bssi_pkg::crd_t'({1'b0, cols_c});
    rows_s = bssi_pkg::crd_t'({1'b0, rows_c});
    oor    = ({1'b0, col_x} >= cols_c) || ({1'b0, row_y} >= rows_c);
    x_fold = x_in;
    y_fold = y_in;
    fc     = cols_s;
    fr     = rows_s;
    if (hr2) begin
      if (x_in >= (cols_s >>> 1)) x_fold = cols_s - x_in - 10'sd1;
      fc = cols_s >>> 1;
    end
    if (vr2) begin
      if (y_in >= (rows_s >>> 1)) y_fold = rows_s - y_in - 10'sd1;
      fr = rows_s >>> 1;
    end
  end

  logic           a_valid;
  bssi_pkg::crd_t a_x;
  bssi_pkg::crd_t a_y;
  bssi_pkg::crd_t a_fc;
  bssi_pkg::crd_t a_fr;
  logic           a_oor;
  logic [16:0]    a_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x   <= x_fold;
      a_y   <= y_fold;
      a_fc  <= fc;
      a_fr  <= fr;
      a_oor <= oor;
      a_seq <= seq[16:0];
    end
  end

  // Stage B: ring number, ring perimeter term and region area.
  bssi_pkg::crd_t min_xy;
  bssi_pkg::crd_t far_x;
  bssi_pkg::crd_t far_y;
  bssi_pkg::crd_t min_far;
  bssi_pkg::crd_t ring;
  bssi_pkg::acc_t span;
  bssi_pkg::acc_t area;

  always_comb begin
    far_x   = a_fc - a_x - 10'sd1;
    far_y   = a_fr - a_y - 10'sd1;
    min_xy  = (a_x < a_y) ? a_x : a_y;
    min_far = (far_x < far_y) ? far_x : far_y;
    ring    = (min_xy < min_far) ? min_xy : min_far;
    span    = (bssi_pkg::acc_t'(a_fc) + bssi_pkg::acc_t'(a_fr) - 20'sd2) <<< 1;
    area    = bssi_pkg::acc_t'(a_fc) * bssi_pkg::acc_t'(a_fr);
  end

  logic           b_valid;
  bssi_pkg::crd_t b_x;
  bssi_pkg::crd_t b_y;
  bssi_pkg::crd_t b_fc;
  bssi_pkg::crd_t b_fr;
  bssi_pkg::crd_t b_ring;
  bssi_pkg::acc_t b_span;
  bssi_pkg::acc_t b_area;
  logic           b_oor;
  logic [16:0]    b_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_x    <= a_x;
      b_y    <= a_y;
      b_fc   <= a_fc;
      b_fr   <= a_fr;
      b_ring <= ring;
      b_span <= span;
      b_area <= area;
      b_oor  <= a_oor;
      b_seq  <= a_seq;
    end
  end

  // Stage C: cells in outer rings, the leg of this cell, leg lengths and offset.
  bssi_pkg::acc_t ring_w;
  bssi_pkg::acc_t base;
  bssi_pkg::leg_t leg;
  bssi_pkg::crd_t in_lo_x;
  bssi_pkg::crd_t in_lo_y;
  bssi_pkg::crd_t in_hi_x;
  bssi_pkg::crd_t in_hi_y;
  bssi_pkg::crd_t edge_x;
  bssi_pkg::crd_t edge_y;
  bssi_pkg::crd_t side_c;
  bssi_pkg::crd_t side_r;
  bssi_pkg::crd_t off;
  bssi_pkg::crd_t len_a;
  bssi_pkg::crd_t len_b;
  logic           single_row;

  always_comb begin
    ring_w     = bssi_pkg::acc_t'(b_ring);
    base       = (b_ring > 10'sd0) ? ring_w * (b_span - (ring_w <<< 2) + 20'sd4) : '0;
    edge_x     = b_fc - b_ring - 10'sd1;
    edge_y     = b_fr - b_ring - 10'sd1;
    in_lo_x    = b_x - b_ring;
    in_lo_y    = b_y - b_ring;
    in_hi_x    = b_fc - b_x - b_ring - 10'sd1;
    in_hi_y    = b_fr - b_y - b_ring - 10'sd1;
    side_c     = b_fc - (b_ring <<< 1) - 10'sd1;
    side_r     = b_fr - (b_ring <<< 1) - 10'sd1;
    single_row = ((b_ring <<< 1) + 10'sd1) == b_fr;
    leg        = bssi_pkg::LEG_0;
    if (clockwise) begin
      if (b_y == b_ring) leg = bssi_pkg::LEG_0;
      if (b_x == edge_x) leg = bssi_pkg::LEG_1;
      if (b_y == edge_y) leg = bssi_pkg::LEG_2;
      if (b_x == b_ring && b_y != b_ring) leg = bssi_pkg::LEG_3;
      if (single_row && (fl == bssi_pkg::LEG_0 || fl == bssi_pkg::LEG_3)) begin
        leg = bssi_pkg::LEG_0;
      end
      len_a = fl[0] ? side_r : side_c;
      len_b = fl[0] ? side_c : side_r;
      case (leg)
        bssi_pkg::LEG_0: off = in_lo_x;
        bssi_pkg::LEG_1: off = in_lo_y;
        bssi_pkg::LEG_2: off = in_hi_x;
        default:         off = in_hi_y;
      endcase
    end else begin
      if (b_x == b_ring) leg = bssi_pkg::LEG_0;
      if (b_y == edge_y) leg = bssi_pkg::LEG_1;
      if (b_x == edge_x) leg = bssi_pkg::LEG_2;
      if (b_y == b_ring && b_x != b_ring) leg = bssi_pkg::LEG_3;
      if (single_row && (fl == bssi_pkg::LEG_0 || fl == bssi_pkg::LEG_1)) begin
        leg = bssi_pkg::LEG_1;
      end
      len_a = fl[0] ? side_c : side_r;
      len_b = fl[0] ? side_r : side_c;
      case (leg)
        bssi_pkg::LEG_0: off = in_lo_y;
        bssi_pkg::LEG_1: off = in_lo_x;
        bssi_pkg::LEG_2: off = in_hi_y;
        default:         off = in_hi_x;
      endcase
    end
  end

  logic           c_valid;
  bssi_pkg::acc_t c_base;
  bssi_pkg::leg_t c_leg;
  bssi_pkg::crd_t c_len_a;
  bssi_pkg::crd_t c_len_b;
  bssi_pkg::crd_t c_off;
  bssi_pkg::acc_t c_area;
  logic           c_oor;
  logic [16:0]    c_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_base  <= base;
      c_leg   <= leg;
      c_len_a <= len_a;
      c_len_b <= len_b;
      c_off   <= off;
      c_area  <= b_area;
      c_oor   <= b_oor;
      c_seq   <= b_seq;
    end
  end

  // Stage D: legs walked before this one, then the forward or reverse position.
  logic [1:0]     legs_done;
  bssi_pkg::acc_t len_a_w;
  bssi_pkg::acc_t pass;
  bssi_pkg::acc_t pos;

  always_comb begin
    legs_done = c_leg - fl;
    len_a_w   = bssi_pkg::acc_t'(c_len_a);
    pass      = c_base + bssi_pkg::acc_t'(c_off);
    if (legs_done >= 2'd1) pass = pass + len_a_w;
    if (legs_done >= 2'd2) pass = pass + bssi_pkg::acc_t'(c_len_b);
    if (legs_done == 2'd3) pass = pass + len_a_w;
    pos = reverse_order ? c_area - pass - 20'sd1 : pass;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      order_index     <= c_oor ? 16'd0 : pos[15:0];
      sequence_length <= c_seq;
      out_of_range    <= c_oor;
    end
  end

`ifndef SYNTH
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> order_index == 16'd0)
    else $error("out of range beat carries a nonzero index");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without an output stall");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sequence_length <= 17'd65536)
    else $error("sequence length above the largest grid");
`endif

endmodule

### test/box_snake_spiral_index_tb.sv
`timescale 1ns / 1ps

module box_snake_spiral_index_tb;

  localparam int LATENCY = 4;
  localparam int LONG_HOLD = 80;
  localparam int CELLS_PER_SETTING = 31;
  localparam int FIXED_SETTINGS = 10;
  localparam int RANDOM_SETTINGS = 4;
  localparam int QUIET_SETTINGS = 3;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [15:0] order;
    logic [16:0] length;
    logic        outside;
  } order_beat_t;

  typedef struct packed {
    logic [7:0]  cx;
    logic [7:0]  ry;
    logic        typed;
    order_beat_t beat;
  } cell_row_t;

  typedef struct packed {
    logic [8:0] cols;
    logic [8:0] rows;
    logic [1:0] hrep;
    logic [1:0] vrep;
    logic       cw;
    logic       rev;
  } grid_setting_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [8:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  col_x;
  logic [7:0]  row_y;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] order_index;
  logic [16:0] sequence_length;
  logic        out_of_range;

  box_snake_spiral_index u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .col_x           (col_x),
    .row_y           (row_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .order_index     (order_index),
    .sequence_length (sequence_length),
    .out_of_range    (out_of_range)
  );

  // Register copies as seen by the block.
  logic [8:0] cur_cols = bssi_pkg::RST_COLUMNS;
  logic [8:0] cur_rows = bssi_pkg::RST_ROWS;
  logic [1:0] cur_hrep = bssi_pkg::RST_REPEAT;
  logic [1:0] cur_vrep = bssi_pkg::RST_REPEAT;
  logic       cur_cw   = 1'b1;
  logic       cur_rev  = 1'b0;

  order_beat_t pending_orders[$];
  int errors = 0;
  int n_cells = 0;
  int n_outside = 0;
  int n_mirrored = 0;
  int n_settings = 0;
  int cycle_count;
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;

  cell_row_t dir_rows [22] = '{
    '{8'd0,   8'd0,   1'b1, '{16'd0,  17'd64, 1'b0}},
    '{8'd7,   8'd0,   1'b1, '{16'd7,  17'd64, 1'b0}},
    '{8'd7,   8'd7,   1'b1, '{16'd14, 17'd64, 1'b0}},
    '{8'd0,   8'd7,   1'b1, '{16'd21, 17'd64, 1'b0}},
    '{8'd8,   8'd0,   1'b1, '{16'd0,  17'd64, 1'b1}},
    '{8'd0,   8'd8,   1'b1, '{16'd0,  17'd64, 1'b1}},
    '{8'd255, 8'd255, 1'b1, '{16'd0,  17'd64, 1'b1}},
    '{8'd255, 8'd0,   1'b1, '{16'd0,  17'd64, 1'b1}},
    '{8'd0,   8'd255, 1'b1, '{16'd0,  17'd64, 1'b1}},
    '{8'd170, 8'd85,  1'b1, '{16'd0,  17'd64, 1'b1}},
    '{8'd1,   8'd1,   1'b0, '0},
    '{8'd3,   8'd3,   1'b0, '0},
    '{8'd4,   8'd4,   1'b0, '0},
    '{8'd3,   8'd4,   1'b0, '0},
    '{8'd4,   8'd3,   1'b0, '0},
    '{8'd0,   8'd1,   1'b0, '0},
    '{8'd1,   8'd0,   1'b0, '0},
    '{8'd6,   8'd1,   1'b0, '0},
    '{8'd1,   8'd6,   1'b0, '0},
    '{8'd5,   8'd2,   1'b0, '0},
    '{8'd2,   8'd5,   1'b0, '0},
    '{8'd6,   8'd6,   1'b0, '0}
  };

  grid_setting_t settings [FIXED_SETTINGS + RANDOM_SETTINGS] = '{
    '{9'd256, 9'd256, 2'd1, 2'd1, 1'b1, 1'b0},
    '{9'd2,   9'd2,   2'd2, 2'd2, 1'b0, 1'b1},
    '{9'd256, 9'd256, 2'd2, 2'd2, 1'b0, 1'b1},
    '{9'd7,   9'd5,   2'd2, 2'd1, 1'b1, 1'b0},
    '{9'd5,   9'd7,   2'd1, 2'd2, 1'b0, 1'b1},
    '{9'd9,   9'd3,   2'd2, 2'd1, 1'b0, 1'b0},
    '{9'd0,   9'd6,   2'd3, 2'd0, 1'b1, 1'b0},
    '{9'd1,   9'd1,   2'd2, 2'd2, 1'b1, 1'b1},
    '{9'd511, 9'd300, 2'd1, 2'd2, 1'b1, 1'b1},
    '{9'd6,   9'd1,   2'd1, 2'd1, 1'b0, 1'b0},
    '0, '0, '0, '0
  };

  function automatic int min_int(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic order_beat_t spiral_order_of(logic [7:0] cx, logic [7:0] ry);
    int cols, rows, hr, vr, x, y, fl, ring, span, passed, leg, len_a, len_b, pos;
    order_beat_t r;
    cols = (cur_cols > bssi_pkg::MAX_DIM) ? int'(bssi_pkg::MAX_DIM) : int'(cur_cols);
    rows = (cur_rows > bssi_pkg::MAX_DIM) ? int'(bssi_pkg::MAX_DIM) : int'(cur_rows);
    hr = (cur_hrep == bssi_pkg::REPEAT_MIRROR) ? 2 : 1;
    vr = (cur_vrep == bssi_pkg::REPEAT_MIRROR) ? 2 : 1;
    x = int'(cx);
    y = int'(ry);
    r.length = 17'(cols * rows / hr / vr);
    if (x >= cols || y >= rows) begin
      r.order = '0;
      r.outside = 1'b1;
      return r;
    end
    // Fold the mirrored halves onto the top-left region.
    if (hr == 2) begin
      if (x >= cols / 2) x = cols - x - 1;
      cols = cols / 2;
    end
    if (vr == 2) begin
      if (y >= rows / 2) y = rows - y - 1;
      rows = rows / 2;
    end
    if (vr == 1 && hr == 2) fl = cur_cw ? 3 : 0;
    else if (vr == 2 && hr == 1) fl = cur_cw ? 0 : 3;
    else fl = 0;
    ring = min_int(min_int(x, y), min_int(cols - x - 1, rows - y - 1));
    span = (cols + rows - 2) * 2;
    passed = 0;
    if (ring > 0) passed = ring * (span + span - (ring - 1) * 8) / 2;
    leg = 0;
    if (cur_cw) begin
      if (y == ring) leg = 0;
      if (x == cols - ring - 1) leg = 1;
      if (y == rows - ring - 1) leg = 2;
      if (x == ring && y != ring) leg = 3;
      if (ring * 2 + 1 == rows && (fl == 0 || fl == 3)) leg = 0;
      len_a = (((fl & 1) != 0) ? rows : cols) - 2 * ring - 1;
      len_b = (((fl & 1) != 0) ? cols : rows) - 2 * ring - 1;
    end else begin
      if (x == ring) leg = 0;
      if (y == rows - ring - 1) leg = 1;
      if (x == cols - ring - 1) leg = 2;
      if (y == ring && x != ring) leg = 3;
      if (ring * 2 + 1 == rows && (fl == 0 || fl == 1)) leg = 1;
      len_a = (((fl & 1) != 0) ? cols : rows) - 2 * ring - 1;
      len_b = (((fl & 1) != 0) ? rows : cols) - 2 * ring - 1;
    end
    if (leg < fl) leg += 4;
    if (leg > fl && leg < fl + 4) passed += len_a;
    if (leg > fl + 1 && leg < fl + 4) passed += len_b;
    if (leg > fl + 2 && leg < fl + 4) passed += len_a;
    if (leg > 3) leg -= 4;
    if (cur_cw) begin
      if (leg == 0) passed += x - ring;
      else if (leg == 1) passed += y - ring;
      else if (leg == 2) passed += cols - x - ring - 1;
      else passed += rows - y - ring - 1;
    end else begin
      if (leg == 0) passed += y - ring;
      else if (leg == 1) passed += x - ring;
      else if (leg == 2) passed += rows - y - ring - 1;
      else passed += cols - x - ring - 1;
    end
    pos = cur_rev ? cols * rows - passed - 1 : passed;
    r.order = pos[15:0];
    r.outside = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] pick_coord(logic [8:0] dim);
    int lim;
    lim = (dim > 9'd256) ? 256 : int'(dim);
    if (lim == 0 || $urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, lim - 1));
  endfunction

  // Called just after a falling edge; returns just after the falling edge that
  // follows acceptance, leaving in_valid high.
  task automatic offer_cell(logic [7:0] cx, logic [7:0] ry, bit typed, order_beat_t beat);
    in_valid <= 1'b1;
    col_x <= cx;
    row_y <= ry;
    do @(posedge clk); while (!in_ready);
    pending_orders.push_back(typed ? beat : spiral_order_of(cx, ry));
    n_cells++;
    if (cx >= cur_cols || ry >= cur_rows) n_outside++;
    if (cur_hrep == bssi_pkg::REPEAT_MIRROR || cur_vrep == bssi_pkg::REPEAT_MIRROR) begin
      n_mirrored++;
    end
    @(negedge clk);
  endtask

  task automatic wait_all_results(int settle);
    while (pending_orders.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic apply_setting(grid_setting_t s);
    cur_cols = s.cols;
    cur_rows = s.rows;
    cur_hrep = s.hrep;
    cur_vrep = s.vrep;
    cur_cw = s.cw;
    cur_rev = s.rev;
    cfg_write <= 1'b1;
    cfg_index <= bssi_pkg::REG_COLUMNS;
    cfg_data <= s.cols;
    @(negedge clk);
    cfg_index <= bssi_pkg::REG_ROWS;
    cfg_data <= s.rows;
    @(negedge clk);
    cfg_index <= bssi_pkg::REG_HOR_REPEAT;
    cfg_data <= {7'd0, s.hrep};
    @(negedge clk);
    cfg_index <= bssi_pkg::REG_VER_REPEAT;
    cfg_data <= {7'd0, s.vrep};
    @(negedge clk);
    cfg_index <= bssi_pkg::REG_CLOCKWISE;
    cfg_data <= {8'd0, s.cw};
    @(negedge clk);
    cfg_index <= bssi_pkg::REG_REVERSE;
    cfg_data <= {8'd0, s.rev};
    @(negedge clk);
    cfg_write <= 1'b0;
    n_settings++;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_orders.size() == 0) begin
        $display("%0t: result with nothing expected: order %0d length %0d outside %0b",
                 $time, order_index, sequence_length, out_of_range);
        errors++;
      end else begin
        if (order_index !== pending_orders[0].order) begin
          $display("%0t: order_index expected %0d actual %0d",
                   $time, pending_orders[0].order, order_index);
          errors++;
        end
        if (sequence_length !== pending_orders[0].length) begin
          $display("%0t: sequence_length expected %0d actual %0d",
                   $time, pending_orders[0].length, sequence_length);
          errors++;
        end
        if (out_of_range !== pending_orders[0].outside) begin
          $display("%0t: out_of_range expected %0b actual %0b",
                   $time, pending_orders[0].outside, out_of_range);
          errors++;
        end
        void'(pending_orders.pop_front());
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    int n;
    int k;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        n = $urandom_range(1, 20);
        out_ready <= 1'b1;
        for (k = 0; k < n && !long_hold_req; k++) @(negedge clk);
      end
    end
  end

  initial begin
    int p;
    int i;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    col_x = '0;
    row_y = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      if ($urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      offer_cell(dir_rows[r].cx, dir_rows[r].ry, dir_rows[r].typed, dir_rows[r].beat);
    end
    in_valid <= 1'b0;
    wait_all_results(LATENCY + 2);

    for (p = FIXED_SETTINGS; p < FIXED_SETTINGS + RANDOM_SETTINGS; p++) begin
      settings[p].cols = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                     : 9'($urandom_range(2, 20));
      settings[p].rows = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                     : 9'($urandom_range(2, 20));
      settings[p].hrep = 2'($urandom_range(0, 3));
      settings[p].vrep = 2'($urandom_range(0, 3));
      settings[p].cw = 1'($urandom_range(0, 1));
      settings[p].rev = 1'($urandom_range(0, 1));
    end

    for (p = 0; p < FIXED_SETTINGS + RANDOM_SETTINGS; p++) begin
      apply_setting(settings[p]);
      if (p >= FIXED_SETTINGS + RANDOM_SETTINGS - QUIET_SETTINGS) quiet = 1'b1;
      if (p == 2) long_hold_req = 1'b1;
      for (i = 0; i < CELLS_PER_SETTING; i++) begin
        if (p == 4 && i == CELLS_PER_SETTING / 2) begin
          in_valid <= 1'b0;
          wait_all_results(0);
        end else if (!quiet && p != 2 && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        offer_cell(pick_coord(cur_cols), pick_coord(cur_rows), 1'b0, '0);
      end
      in_valid <= 1'b0;
      wait_all_results(LATENCY + 2);
    end

    repeat (LATENCY * 4) @(negedge clk);
    $display("Checked %0d cells over %0d grid settings plus reset defaults.",
             n_cells, n_settings);
    $display("%0d cells lay outside the grid and %0d used a mirrored layout.",
             n_outside, n_mirrored);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
